// ===== design/pti_pkg.sv =====
// Shared types, constants and helper functions for the periodic trilinear interpolator.
// Used by pti_div, pti_ram users and the top level; depends on nothing.
package pti_pkg;

    localparam int SIZE_X = 16;
    localparam int SIZE_Y = 16;
    localparam int SIZE_Z = 16;

    localparam int GRID_DEPTH = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int ADDR_W     = $clog2(GRID_DEPTH);
    localparam int CELL_W     = 8;

    localparam int DIV_N_W = 48;
    localparam int DIV_D_W = 31 + CELL_W;
    localparam int DIV_C_W = $clog2(DIV_N_W + 1);

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Z  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPACING_X = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPACING_Y = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPACING_Z = 3'd5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_POST,
        ST_READ,
        ST_BLEND,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [ADDR_W-1:0] grid_addr(input logic [CELL_W-1:0] i,
                                                    input logic [CELL_W-1:0] j,
                                                    input logic [CELL_W-1:0] k);
        int unsigned a;
        a = (int'(i) * SIZE_Y + int'(j)) * SIZE_Z + int'(k);
        return a[ADDR_W-1:0];
    endfunction

endpackage

// ===== design/periodic_trilinear_interpolator.sv =====
// Periodic trilinear interpolator: grid store, axis reduction and blend sequencer.
// Depends on pti_pkg, pti_div and pti_ram.
//
// The input channel (s_) carries one command per beat: tuser is the command bit.
// A write beat stores one grid sample and returns nothing, and
// s_tready stays high, so write beats can follow back to back.
// A query beat returns one result beat on the output channel (m_).
// Each query runs three divisions per axis on one shared bit-serial divider: the
// offset by the wrap period, the wrapped offset by the spacing and the scaled
// remainder by the spacing. A division passes through a start state, the 48
// quotient bits, a completion flag and a hand-back state. Eight corner reads
// from the grid memory follow, and then seven blend steps on one multiplier.
// s_tready stays low from the accepted query until its result is loaded into the
// output register, and only then is the next beat taken. The result sits in that
// output register; if the receiver stalls, the block holds its finished result
// and waits before it takes the next beat.
// Configuration registers are written through cfg_we, cfg_addr and cfg_wdata
// while the block is idle: the user must keep to this, as the block itself does
// not enforce it. Reset sets the origins to zero and the spacings to one grid
// unit; grid contents are undefined until written. No clearing pass is run.
module periodic_trilinear_interpolator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [pti_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pti_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // grid_i, grid_j, grid_k, sample_value, query_x, query_y, query_z
    input  logic [pti_pkg::IN_DATA_W-1:0]     s_tdata,
    // command
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // interpolated_value
    output logic [pti_pkg::OUT_DATA_W-1:0]    m_tdata,
    // saturated
    output logic                              m_tuser
);

    pti_pkg::state_t state_reg, state_next;

    logic signed [31:0] origin_reg [3];
    logic [30:0]        spacing_reg [3];
    logic signed [31:0] query_reg [3];

    logic [1:0]  axis_reg;
    logic [1:0]  phase_reg;
    logic        neg_reg;
    logic [pti_pkg::DIV_D_W-1:0] mq_reg;
    logic [30:0] frac_reg;
    logic [pti_pkg::CELL_W-1:0] cell_reg [3];
    logic [15:0] w_reg [3];

    logic [3:0]         rd_cnt_reg;
    logic signed [31:0] corner_reg [8];
    logic [2:0]         step_reg;
    logic signed [31:0] t_reg [4];
    logic signed [33:0] res_reg;

    logic                           m_tvalid_reg;
    logic [pti_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic                           m_tuser_reg;

    logic                          div_start;
    logic [pti_pkg::DIV_N_W-1:0]   div_dividend;
    logic [pti_pkg::DIV_D_W-1:0]   div_divisor;
    pti_pkg::div_status_t          div_status;
    logic [pti_pkg::DIV_N_W-1:0]   div_quo;
    logic [pti_pkg::DIV_D_W-1:0]   div_rem;

    logic                          ram_we;
    logic [pti_pkg::ADDR_W-1:0]    ram_waddr;
    logic [pti_pkg::ADDR_W-1:0]    ram_raddr;
    logic [31:0]                   ram_rdata;

    logic                  s_accept;
    logic                  out_load;
    logic signed [32:0]    off;
    logic [32:0]           off_mag;
    logic [31:0]           div_d;
    logic [pti_pkg::CELL_W:0] size_m1;
    logic [pti_pkg::DIV_D_W-1:0] period;
    logic [2:0]            corner_sel;
    logic signed [31:0]    blend_a, blend_b;
    logic [15:0]           blend_w;
    logic signed [32:0]    blend_diff;
    logic signed [49:0]    blend_prod;
    logic signed [51:0]    blend_sum;
    logic [pti_pkg::CELL_W-1:0] ci, cj, ck;

    assign s_accept = s_tvalid && s_tready;
    assign out_load = (state_reg == pti_pkg::ST_OUT) && (!m_tvalid_reg || m_tready);

    pti_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .status    (div_status),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    pti_ram #(
        .WIDTH (32),
        .DEPTH (pti_pkg::GRID_DEPTH)
    ) u_grid (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata[43:12]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        off     = 33'(query_reg[axis_reg]) - 33'(origin_reg[axis_reg]);
        off_mag = off[32] ? 33'(-off) : 33'(off);
        div_d   = (spacing_reg[axis_reg] == '0) ? 32'd1 : {1'b0, spacing_reg[axis_reg]};
        unique case (axis_reg)
            2'd0:    size_m1 = (pti_pkg::CELL_W+1)'(pti_pkg::SIZE_X - 1);
            2'd1:    size_m1 = (pti_pkg::CELL_W+1)'(pti_pkg::SIZE_Y - 1);
            default: size_m1 = (pti_pkg::CELL_W+1)'(pti_pkg::SIZE_Z - 1);
        endcase
        period = pti_pkg::DIV_D_W'(div_d) * pti_pkg::DIV_D_W'(size_m1);
        unique case (phase_reg)
            2'd0: begin
                div_dividend = pti_pkg::DIV_N_W'(off_mag);
                div_divisor  = period;
            end
            2'd1: begin
                div_dividend = pti_pkg::DIV_N_W'(mq_reg);
                div_divisor  = pti_pkg::DIV_D_W'(div_d);
            end
            default: begin
                div_dividend = {1'b0, frac_reg, 16'd0};
                div_divisor  = pti_pkg::DIV_D_W'(div_d);
            end
        endcase
    end

    always_comb begin
        corner_sel = rd_cnt_reg[2:0];
        ci = cell_reg[0] + pti_pkg::CELL_W'(corner_sel[0]);
        cj = cell_reg[1] + pti_pkg::CELL_W'(corner_sel[1]);
        ck = cell_reg[2] + pti_pkg::CELL_W'(corner_sel[2]);
    end

    always_comb begin
        unique case (step_reg)
            3'd0: begin blend_a = corner_reg[0]; blend_b = corner_reg[1]; blend_w = w_reg[0]; end
            3'd1: begin blend_a = corner_reg[2]; blend_b = corner_reg[3]; blend_w = w_reg[0]; end
            3'd2: begin blend_a = t_reg[0];      blend_b = t_reg[1];      blend_w = w_reg[1]; end
            3'd3: begin blend_a = corner_reg[4]; blend_b = corner_reg[5]; blend_w = w_reg[0]; end
            3'd4: begin blend_a = corner_reg[6]; blend_b = corner_reg[7]; blend_w = w_reg[0]; end
            3'd5: begin blend_a = t_reg[0];      blend_b = t_reg[1];      blend_w = w_reg[1]; end
            default: begin blend_a = t_reg[2]; blend_b = t_reg[3];      blend_w = w_reg[2]; end
        endcase
        blend_diff = 33'(blend_b) - 33'(blend_a);
        blend_prod = blend_diff * $signed({1'b0, blend_w});
        blend_sum  = (52'(blend_a) <<< 16) + 52'(blend_prod) + 52'sd32768;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pti_pkg::ST_IDLE: begin
                if (s_accept && s_tuser == pti_pkg::CMD_QUERY) begin
                    state_next = pti_pkg::ST_LOAD;
                end
            end
            pti_pkg::ST_LOAD: state_next = pti_pkg::ST_DIV;
            pti_pkg::ST_DIV: begin
                if (div_status.done) begin
                    state_next = pti_pkg::ST_POST;
                end
            end
            pti_pkg::ST_POST: begin
                if (phase_reg == 2'd2 && axis_reg == 2'd2) begin
                    state_next = pti_pkg::ST_READ;
                end else begin
                    state_next = pti_pkg::ST_LOAD;
                end
            end
            pti_pkg::ST_READ: begin
                if (rd_cnt_reg == 4'd8) begin
                    state_next = pti_pkg::ST_BLEND;
                end
            end
            pti_pkg::ST_BLEND: begin
                if (step_reg == 3'd6) begin
                    state_next = pti_pkg::ST_OUT;
                end
            end
            pti_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = pti_pkg::ST_IDLE;
                end
            end
            default: state_next = pti_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == pti_pkg::ST_IDLE);
        div_start = (state_reg == pti_pkg::ST_LOAD);
        ram_we    = s_accept && (s_tuser == pti_pkg::CMD_WRITE)
                    && (32'(s_tdata[3:0]) < 32'(pti_pkg::SIZE_X))
                    && (32'(s_tdata[7:4]) < 32'(pti_pkg::SIZE_Y))
                    && (32'(s_tdata[11:8]) < 32'(pti_pkg::SIZE_Z));
        ram_waddr = pti_pkg::grid_addr(pti_pkg::CELL_W'(s_tdata[3:0]),
                                       pti_pkg::CELL_W'(s_tdata[7:4]),
                                       pti_pkg::CELL_W'(s_tdata[11:8]));
        ram_raddr = pti_pkg::grid_addr(ci, cj, ck);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pti_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            origin_reg   <= '{default: '0};
            spacing_reg  <= '{default: 31'd65536};
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_addr)
                    pti_pkg::CFG_ORIGIN_X:  origin_reg[0]  <= cfg_wdata;
                    pti_pkg::CFG_ORIGIN_Y:  origin_reg[1]  <= cfg_wdata;
                    pti_pkg::CFG_ORIGIN_Z:  origin_reg[2]  <= cfg_wdata;
                    pti_pkg::CFG_SPACING_X: spacing_reg[0] <= cfg_wdata[30:0];
                    pti_pkg::CFG_SPACING_Y: spacing_reg[1] <= cfg_wdata[30:0];
                    pti_pkg::CFG_SPACING_Z: spacing_reg[2] <= cfg_wdata[30:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            pti_pkg::ST_IDLE: begin
                query_reg[0] <= s_tdata[75:44];
                query_reg[1] <= s_tdata[107:76];
                query_reg[2] <= s_tdata[139:108];
                axis_reg     <= 2'd0;
                phase_reg    <= 2'd0;
                rd_cnt_reg   <= '0;
                step_reg     <= '0;
            end
            pti_pkg::ST_LOAD: begin
                if (phase_reg == 2'd0) begin
                    neg_reg <= off[32];
                end
            end
            pti_pkg::ST_POST: begin
                unique case (phase_reg)
                    2'd0: begin
                        if (neg_reg && div_rem != '0) begin
                            mq_reg <= period - div_rem;
                        end else begin
                            mq_reg <= div_rem;
                        end
                        phase_reg <= 2'd1;
                    end
                    2'd1: begin
                        cell_reg[axis_reg] <= pti_pkg::CELL_W'(div_quo);
                        frac_reg           <= div_rem[30:0];
                        phase_reg          <= 2'd2;
                    end
                    default: begin
                        w_reg[axis_reg] <= div_quo[15:0];
                        phase_reg       <= 2'd0;
                        axis_reg        <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                    end
                endcase
            end
            pti_pkg::ST_READ: begin
                rd_cnt_reg <= rd_cnt_reg + 4'd1;
                if (rd_cnt_reg != 4'd0) begin
                    corner_reg[3'(rd_cnt_reg - 4'd1)] <= ram_rdata;
                end
            end
            pti_pkg::ST_BLEND: begin
                step_reg <= step_reg + 3'd1;
                unique case (step_reg)
                    3'd0, 3'd3: t_reg[0] <= blend_sum[47:16];
                    3'd1, 3'd4: t_reg[1] <= blend_sum[47:16];
                    3'd2:       t_reg[2] <= blend_sum[47:16];
                    3'd5:       t_reg[3] <= blend_sum[47:16];
                    default:    res_reg  <= blend_sum[49:16];
                endcase
            end
            default: ;
        endcase
        if (out_load) begin
            if (res_reg > 34'sd2147483647) begin
                m_tdata_reg <= 32'h7FFF_FFFF;
                m_tuser_reg <= 1'b1;
            end else if (res_reg < -34'sd2147483648) begin
                m_tdata_reg <= 32'h8000_0000;
                m_tuser_reg <= 1'b1;
            end else begin
                m_tdata_reg <= res_reg[31:0];
                m_tuser_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_div_only_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.busy |-> (state_reg == pti_pkg::ST_DIV))
        else $error("divider busy outside the division state");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == pti_pkg::ST_OUT))
        else $error("result beat raised outside the output state");

    a_read_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pti_pkg::ST_READ) |-> (rd_cnt_reg <= 4'd8))
        else $error("corner read counter overran");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pti_pkg::ST_BLEND) |=> !s_accept)
        else $error("beat accepted while a query is in flight");

endmodule

// ===== design/pti_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module pti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/pti_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pti_pkg for widths and the status struct.
module pti_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [pti_pkg::DIV_N_W-1:0]  dividend,
    input  logic [pti_pkg::DIV_D_W-1:0]  divisor,
    output pti_pkg::div_status_t         status,
    output logic [pti_pkg::DIV_N_W-1:0]  quotient,
    output logic [pti_pkg::DIV_D_W-1:0]  remainder
);

    logic [pti_pkg::DIV_D_W:0]   rem_reg, rem_next;
    logic [pti_pkg::DIV_N_W-1:0] quo_reg, quo_next;
    logic [pti_pkg::DIV_D_W-1:0] den_reg;
    logic [pti_pkg::DIV_C_W-1:0] cnt_reg;
    logic                        busy_reg, done_reg;
    logic [pti_pkg::DIV_D_W:0]   shifted;

    always_comb begin
        shifted = {rem_reg[pti_pkg::DIV_D_W-1:0], quo_reg[pti_pkg::DIV_N_W-1]};
        if (shifted >= {1'b0, den_reg}) begin
            rem_next = shifted - {1'b0, den_reg};
            quo_next = {quo_reg[pti_pkg::DIV_N_W-2:0], 1'b1};
        end else begin
            rem_next = shifted;
            quo_next = {quo_reg[pti_pkg::DIV_N_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == pti_pkg::DIV_C_W'(pti_pkg::DIV_N_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg[pti_pkg::DIV_D_W-1:0];

endmodule

// ===== dv/pti_checker.sv =====
// Watches the configuration port and both stream channels of the periodic trilinear
// interpolator, predicts each query result from its own grid copy and compares it.
// Depends on pti_pkg for sizes, register indexes and command codes.
`timescale 1ns / 100ps

module pti_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [pti_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pti_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [pti_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [pti_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           m_tuser,
    output int unsigned                    fail_count,
    output int unsigned                    pending,
    output int unsigned                    checked
);

    typedef struct {
        logic [31:0] value;
        logic        sat;
    } interp_t;

    logic signed [31:0] grid_copy [pti_pkg::GRID_DEPTH];
    logic signed [31:0] org_x, org_y, org_z;
    logic [30:0]        sp_x, sp_y, sp_z;
    interp_t            interp_q [$];

    assign pending = interp_q.size();

    function automatic void reduce_axis(input longint q, input longint org,
                                        input longint sp, input int size,
                                        output int cell_idx, output longint w);
        longint s, period, r, c, frac;
        s = (sp == 0) ? 1 : sp;
        period = s * (size - 1);
        r = (q - org) % period;
        if (r < 0) r += period;
        c = r / s;
        if (c > size - 2) c = size - 2;
        frac = r - c * s;
        w = (frac * 65536) / s;
        if (w > 65536) w = 65536;
        cell_idx = int'(c);
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint w);
        longint t;
        t = a * (65536 - w) + b * w;
        return (t + 32768) >>> 16;
    endfunction

    function automatic longint corner(input int i, input int j, input int k);
        return longint'(grid_copy[(i * pti_pkg::SIZE_Y + j) * pti_pkg::SIZE_Z + k]);
    endfunction

    function automatic interp_t interpolate(input logic [pti_pkg::IN_DATA_W-1:0] d);
        int      ci, cj, ck;
        longint  wx, wy, wz, y0, y1, z0, z1, v;
        interp_t res;
        reduce_axis(longint'($signed(d[75:44])), org_x, sp_x, pti_pkg::SIZE_X, ci, wx);
        reduce_axis(longint'($signed(d[107:76])), org_y, sp_y, pti_pkg::SIZE_Y, cj, wy);
        reduce_axis(longint'($signed(d[139:108])), org_z, sp_z, pti_pkg::SIZE_Z, ck, wz);
        y0 = blend(corner(ci, cj, ck), corner(ci + 1, cj, ck), wx);
        y1 = blend(corner(ci, cj + 1, ck), corner(ci + 1, cj + 1, ck), wx);
        z0 = blend(y0, y1, wy);
        y0 = blend(corner(ci, cj, ck + 1), corner(ci + 1, cj, ck + 1), wx);
        y1 = blend(corner(ci, cj + 1, ck + 1), corner(ci + 1, cj + 1, ck + 1), wx);
        z1 = blend(y0, y1, wy);
        v = blend(z0, z1, wz);
        res.sat = 1'b0;
        if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
            res.sat = 1'b1;
        end
        if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
            res.sat = 1'b1;
        end
        res.value = v[31:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        interp_t exp_res;
        int      i, j, k;
        if (!aresetn) begin
            org_x <= '0;
            org_y <= '0;
            org_z <= '0;
            sp_x <= 31'd65536;
            sp_y <= 31'd65536;
            sp_z <= 31'd65536;
            interp_q.delete();
            fail_count <= 0;
            checked <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    pti_pkg::CFG_ORIGIN_X:  org_x <= cfg_wdata;
                    pti_pkg::CFG_ORIGIN_Y:  org_y <= cfg_wdata;
                    pti_pkg::CFG_ORIGIN_Z:  org_z <= cfg_wdata;
                    pti_pkg::CFG_SPACING_X: sp_x <= cfg_wdata[30:0];
                    pti_pkg::CFG_SPACING_Y: sp_y <= cfg_wdata[30:0];
                    pti_pkg::CFG_SPACING_Z: sp_z <= cfg_wdata[30:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == pti_pkg::CMD_WRITE) begin
                    i = int'(s_tdata[3:0]);
                    j = int'(s_tdata[7:4]);
                    k = int'(s_tdata[11:8]);
                    if (i < pti_pkg::SIZE_X && j < pti_pkg::SIZE_Y && k < pti_pkg::SIZE_Z)
                        grid_copy[(i * pti_pkg::SIZE_Y + j) * pti_pkg::SIZE_Z + k]
                            = s_tdata[43:12];
                end else begin
                    interp_q.push_back(interpolate(s_tdata));
                end
            end
            if (m_tvalid && m_tready) begin
                if (interp_q.size() == 0) begin
                    $display("%0t: unexpected result beat, actual value %h sat %b",
                             $time, m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_res = interp_q.pop_front();
                    checked <= checked + 1;
                    if (m_tdata !== exp_res.value || m_tuser !== exp_res.sat) begin
                        $display("%0t: mismatch, expected value %h sat %b, actual %h sat %b",
                                 $time, exp_res.value, exp_res.sat, m_tdata, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Stimulus and verdict for the periodic trilinear interpolator: fills the grid, then
// runs directed and random queries and rewrites under several register settings.
// Depends on pti_pkg, the block itself and pti_checker.
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 800000;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [pti_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [pti_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [pti_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                           s_tuser = pti_pkg::CMD_WRITE;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [pti_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tuser;
    int unsigned                    fail_count, pending, checked;
    int unsigned                    cycle_count = 0;
    bit                             quiet = 1'b0;
    int unsigned                    stall_left = 0;
    int unsigned                    query_count = 0;
    logic signed [31:0]             cur_org [3];
    longint                         cur_sp [3];

    periodic_trilinear_interpolator dut (.*);

    pti_checker checker_i (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("periodic_trilinear_interpolator test failed");
            $finish;
        end
    end

    // The receiver stalls in bursts, with stretches of steady readiness between.
    always @(posedge aclk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 12) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_beat(input logic cmd, input logic [pti_pkg::IN_DATA_W-1:0] data);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
        if (cmd == pti_pkg::CMD_QUERY) query_count++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic write_sample(input int i, input int j, input int k,
                                input logic [31:0] v);
        logic [pti_pkg::IN_DATA_W-1:0] d;
        d = pti_pkg::IN_DATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        d[3:0] = 4'(i);
        d[7:4] = 4'(j);
        d[11:8] = 4'(k);
        d[43:12] = v;
        send_beat(pti_pkg::CMD_WRITE, d);
    endtask

    task automatic query_point(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z);
        logic [pti_pkg::IN_DATA_W-1:0] d;
        d = pti_pkg::IN_DATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        d[75:44] = x;
        d[107:76] = y;
        d[139:108] = z;
        d[143:140] = '0;
        send_beat(pti_pkg::CMD_QUERY, d);
    endtask

    // A coordinate that lands on a chosen cell, often exactly on a grid line, and is
    // shifted by up to two periods either way; otherwise fully random.
    function automatic logic [31:0] pick_coord(input int axis_n);
        longint c, f;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: c = 0;
            default: c = $urandom_range(0, 14);
        endcase
        f = ($urandom_range(0, 2) == 0) ? 0 : longint'($urandom) % cur_sp[axis_n];
        c = longint'(cur_org[axis_n]) + c * cur_sp[axis_n] + f
            + longint'($signed($urandom_range(0, 4)) - 2) * 15 * cur_sp[axis_n];
        return c[31:0];
    endfunction

    task automatic set_config(input logic [31:0] ox, input logic [31:0] oy,
                              input logic [31:0] oz, input logic [30:0] sx,
                              input logic [30:0] sy, input logic [30:0] sz);
        logic [31:0] vals [6];
        vals = '{ox, oy, oz, {1'b0, sx}, {1'b0, sy}, {1'b0, sz}};
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        for (int n = 0; n < 6; n++) begin
            cfg_we <= 1'b1;
            cfg_addr <= n[pti_pkg::CFG_ADDR_W-1:0];
            cfg_wdata <= vals[n];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        cur_org = '{ox, oy, oz};
        cur_sp = '{sx, sy, sz};
    endtask

    task automatic random_phase(input int n_items);
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(0, 4) == 0)
                write_sample($urandom_range(0, 15), $urandom_range(0, 15),
                             $urandom_range(0, 15), $urandom);
            else
                query_point(pick_coord(0), pick_coord(1), pick_coord(2));
        end
    endtask

    initial begin
        cur_org = '{0, 0, 0};
        cur_sp = '{65536, 65536, 65536};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int n = 0; n < pti_pkg::GRID_DEPTH; n++)
            write_sample(n / (pti_pkg::SIZE_Y * pti_pkg::SIZE_Z),
                         (n / pti_pkg::SIZE_Z) % pti_pkg::SIZE_Y,
                         n % pti_pkg::SIZE_Z, $urandom);
        write_sample(0, 0, 0, 32'h7fffffff);
        write_sample(1, 0, 0, 32'h7fffffff);
        write_sample(15, 15, 15, 32'h80000000);
        write_sample(14, 15, 15, 32'h80000000);
        write_sample(0, 1, 0, 32'h00000000);
        write_sample(0, 0, 1, 32'hffffffff);

        query_point(32'h0, 32'h0, 32'h0);
        query_point(32'h00008000, 32'h00008000, 32'h00008000);
        query_point(32'hffffffff, 32'hffffffff, 32'hffffffff);
        query_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        query_point(32'h80000000, 32'h7fffffff, 32'h80000000);
        query_point(32'h000f0000, 32'h000e0000, 32'h000effff);
        query_point(32'hfff10000, 32'h001e0000, 32'h000f0001);
        query_point(32'h000e8000, 32'h000e8000, 32'h000e8000);
        random_phase(70);

        set_config($urandom, $urandom, $urandom, $urandom_range(1, 400000),
                   $urandom_range(1, 400000), $urandom_range(1, 400000));
        random_phase(70);
        set_config(32'h80000000, 32'h7fffffff, 32'h0, 31'd1, 31'd1, 31'd1);
        query_point(32'h80000000, 32'h7fffffff, 32'h0000000f);
        random_phase(70);
        set_config(32'h7fffffff, 32'h80000000, 32'hffffffff, 31'h7fffffff,
                   31'h7fffffff, 31'h7fffffff);
        query_point(32'h80000000, 32'h7fffffff, 32'h0);
        random_phase(70);
        set_config($urandom, 32'h0, $urandom, 31'd3, $urandom, 31'h7fffffff);
        random_phase(60);
        quiet = 1'b1;
        random_phase(40);
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        $display("Filled the %0d-entry grid, checked %0d of %0d query results",
                 pti_pkg::GRID_DEPTH, checked, query_count);
        $display("over five register settings including the origin and spacing extremes.");
        if (fail_count == 0)
            $display("periodic_trilinear_interpolator test passed");
        else
            $display("periodic_trilinear_interpolator test failed");
        $finish;
    end

endmodule
